[rtl/ketp_pkg.sv]
// Shared types and defaults for the key/text event line parser.
package ketp_pkg;

	localparam int MAX_MODS_DEF   = 8;
	localparam int CODE_WIDTH_DEF = 32;
	localparam int CODE_W_MAX     = 32;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_TEXT    = 2'd1,
		KIND_STROKE  = 2'd2,
		KIND_RELEASE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REC_TEXT   = 2'd0,
		REC_HEADER = 2'd1,
		REC_MOD    = 2'd2
	} rec_t;

	// One command from the parser front to the record back end.
	typedef struct packed {
		logic                  text_vld;
		logic [7:0]            text_byte;
		logic                  mod_vld;
		logic [CODE_W_MAX-1:0] mod_val;
		logic                  end_vld;
		kind_t                 kind;
		logic [CODE_W_MAX-1:0] key;
	} cmd_t;

endpackage

[rtl/ketp_front.sv]
// Character parser: classifies each byte of the line and issues commands.
module ketp_front
	import ketp_pkg::*;
#(
	parameter int MAX_MODS   = MAX_MODS_DEF,
	parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	output cmd_t       cmd
);

	localparam int CNT_W = $clog2(MAX_MODS + 1);

	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_K      = 8'h6B;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_M      = 8'h6D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;

	typedef enum logic [8:0] {
		PH_START      = 9'b000000001,
		PH_TEXT       = 9'b000000010,
		PH_KCODE      = 9'b000000100,
		PH_AFTER_CODE = 9'b000001000,
		PH_AFTER_REL  = 9'b000010000,
		PH_BRACE      = 9'b000100000,
		PH_MODWS      = 9'b001000000,
		PH_MODHEX     = 9'b010000000,
		PH_DONE       = 9'b100000000
	} phase_t;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	function automatic logic white(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
			c == 8'h0B || c == 8'h0C;
	endfunction

	phase_t                phase_q, phase_n;
	kind_t                 kind_q, kind_n;
	logic [CODE_WIDTH-1:0] acc_q, acc_n;
	logic                  run_q, run_n;
	logic [3:0]            hn_q, hn_n;
	logic                  pos_q, pos_n;
	logic                  hv_q, hv_n;
	logic [CODE_WIDTH-1:0] key_q, key_n;
	logic [CNT_W-1:0]      mcnt_q, mcnt_n;

	logic [4:0]            hd;
	logic                  is_hex, is_ws;
	logic [3:0]            hexv;
	logic [CODE_WIDTH-1:0] acc_shift;
	phase_t                ac_phase;
	cmd_t                  cmd_n;

	always_comb begin
		hd        = hex_digit(in_byte);
		is_hex    = hd[4];
		hexv      = hd[3:0];
		is_ws     = white(in_byte);
		acc_shift = {acc_q[CODE_WIDTH-5:0], hexv};
		if (is_ws) begin
			ac_phase = PH_AFTER_CODE;
		end else if (in_byte == CH_CARET) begin
			ac_phase = PH_AFTER_REL;
		end else if (in_byte == CH_M) begin
			ac_phase = PH_BRACE;
		end else begin
			ac_phase = PH_DONE;
		end
	end

	always_comb begin
		phase_n = phase_q;
		kind_n  = kind_q;
		acc_n   = acc_q;
		run_n   = run_q;
		hn_n    = hn_q;
		pos_n   = pos_q;
		hv_n    = hv_q;
		key_n   = key_q;
		mcnt_n  = mcnt_q;
		cmd_n   = '0;
		cmd_n.kind = KIND_NONE;

		unique case (phase_q)
			PH_START: begin
				acc_n = '0;
				run_n = 1'b0;
				if (in_byte == CH_T) begin
					kind_n  = KIND_TEXT;
					phase_n = PH_TEXT;
				end else if (in_byte == CH_K) begin
					kind_n  = KIND_STROKE;
					phase_n = PH_KCODE;
				end else begin
					kind_n  = KIND_NONE;
					phase_n = PH_DONE;
				end
			end
			PH_TEXT: begin
				if (!pos_q) begin
					hv_n  = is_hex;
					hn_n  = is_hex ? hexv : 4'h0;
					pos_n = 1'b1;
				end else begin
					cmd_n.text_vld  = hv_q && is_hex;
					cmd_n.text_byte = {hn_q, hexv};
					pos_n = 1'b0;
					hv_n  = 1'b0;
				end
			end
			PH_KCODE: begin
				if (is_hex) begin
					acc_n = acc_shift;
					run_n = 1'b1;
				end else if (!run_q) begin
					kind_n  = KIND_NONE;
					phase_n = PH_DONE;
				end else begin
					// close the code and run this byte through the next step
					key_n   = acc_q;
					phase_n = ac_phase;
					if (ac_phase == PH_AFTER_REL) begin
						kind_n = KIND_RELEASE;
					end
				end
			end
			PH_AFTER_CODE: begin
				phase_n = ac_phase;
				if (ac_phase == PH_AFTER_REL) begin
					kind_n = KIND_RELEASE;
				end
			end
			PH_AFTER_REL: begin
				if (!is_ws) begin
					phase_n = (in_byte == CH_M) ? PH_BRACE : PH_DONE;
				end
			end
			PH_BRACE: begin
				phase_n = (in_byte == CH_LBRACE) ? PH_MODWS : PH_DONE;
			end
			PH_MODWS: begin
				if (is_hex) begin
					acc_n   = CODE_WIDTH'(hexv);
					phase_n = PH_MODHEX;
				end else if (!is_ws) begin
					phase_n = PH_DONE;
				end
			end
			PH_MODHEX: begin
				if (is_hex) begin
					acc_n = acc_shift;
				end else begin
					cmd_n.mod_vld = 1'b1;
					cmd_n.mod_val = CODE_W_MAX'(acc_q);
					mcnt_n        = mcnt_q + CNT_W'(1);
					if (mcnt_q == CNT_W'(MAX_MODS - 1)) begin
						phase_n = PH_DONE;
					end else if (is_ws) begin
						phase_n = PH_MODWS;
					end else begin
						phase_n = PH_DONE;
					end
				end
			end
			PH_DONE: begin
				phase_n = PH_DONE;
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase

		if (in_last) begin
			if (phase_n == PH_KCODE) begin
				if (run_n) begin
					key_n = acc_n;
				end else begin
					kind_n = KIND_NONE;
				end
			end else if (phase_n == PH_MODHEX) begin
				cmd_n.mod_vld = 1'b1;
				cmd_n.mod_val = CODE_W_MAX'(acc_n);
			end
			cmd_n.end_vld = 1'b1;
			cmd_n.kind    = kind_n;
			cmd_n.key     = CODE_W_MAX'(key_n);
			// back to start of line
			phase_n = PH_START;
			kind_n  = KIND_NONE;
			acc_n   = '0;
			run_n   = 1'b0;
			hn_n    = 4'h0;
			pos_n   = 1'b0;
			hv_n    = 1'b0;
			key_n   = '0;
			mcnt_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			kind_q  <= KIND_NONE;
			acc_q   <= '0;
			run_q   <= 1'b0;
			hn_q    <= 4'h0;
			pos_q   <= 1'b0;
			hv_q    <= 1'b0;
			key_q   <= '0;
			mcnt_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			kind_q  <= kind_n;
			acc_q   <= acc_n;
			run_q   <= run_n;
			hn_q    <= hn_n;
			pos_q   <= pos_n;
			hv_q    <= hv_n;
			key_q   <= key_n;
			mcnt_q  <= mcnt_n;
		end
	end

	assign push = accept && (cmd_n.text_vld || cmd_n.mod_vld || cmd_n.end_vld);
	assign cmd  = cmd_n;

	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> phase_q == PH_START && mcnt_q == '0)
		else $error("parser did not return to start of line");

	a_pair_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_TEXT |-> !pos_q && !hv_q)
		else $error("pair state live outside text phase");

	a_mod_limit: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MODHEX |-> mcnt_q < CNT_W'(MAX_MODS))
		else $error("modifier run open past the limit");

endmodule

[rtl/ketp_queue.sv]
// Short command queue between the parser front and the record back end.
module ketp_queue
	import ketp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_vld,
	output cmd_t head_cmd
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_pop;

	assign full     = cnt_q == (PTR_W+1)'(DEPTH);
	assign head_vld = cnt_q != '0;
	assign head_cmd = slot_q[rd_q];
	assign do_pop   = pop && head_vld;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_vld)
		else $error("command popped from an empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PTR_W+1)'(DEPTH))
		else $error("queue count out of range");

endmodule

[rtl/ketp_back.sv]
// Record generator: turns queued commands into output records, walks stored modifiers.
module ketp_back
	import ketp_pkg::*;
#(
	parameter int MAX_MODS   = MAX_MODS_DEF,
	parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_vld,
	input  cmd_t        head_cmd,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic [3:0]  m_tuser,
	output logic        m_tlast
);

	localparam int CNT_W = $clog2(MAX_MODS + 1);
	localparam int IDX_W = (MAX_MODS > 1) ? $clog2(MAX_MODS) : 1;

	typedef enum logic [1:0] {
		S_HEAD = 2'b01,
		S_MODS = 2'b10
	} bstate_t;

	bstate_t               state_q;
	logic [CODE_WIDTH-1:0] store_q [MAX_MODS];
	logic [CNT_W-1:0]      cnt_q, total_q, idx_q, total_w;
	kind_t                 walk_kind_q;
	logic                  text_done_q;

	logic                  out_vld_q;
	rec_t                  type_q;
	kind_t                 kind_q;
	logic [31:0]           value_q;
	logic [3:0]            count_q;
	logic                  last_q;

	logic                  out_free, key_kind, st_we, ld;
	logic                  take_text, take_end, take_mod, ld_mod, walk_last;
	rec_t                  rec_type;
	kind_t                 rec_kind;
	logic [31:0]           rec_value;
	logic [3:0]            rec_count;
	logic                  rec_last;

	assign out_free  = !out_vld_q || m_tready;
	assign key_kind  = head_cmd.kind == KIND_STROKE || head_cmd.kind == KIND_RELEASE;
	assign total_w   = key_kind ? cnt_q + CNT_W'(head_cmd.mod_vld) : '0;
	assign walk_last = (idx_q + CNT_W'(1)) == total_q;

	always_comb begin
		pop       = 1'b0;
		take_text = 1'b0;
		take_end  = 1'b0;
		take_mod  = 1'b0;
		ld_mod    = 1'b0;
		unique case (state_q)
			S_HEAD: begin
				if (head_vld) begin
					if (head_cmd.text_vld && !text_done_q) begin
						take_text = out_free;
						pop       = out_free && !head_cmd.end_vld;
					end else if (head_cmd.end_vld) begin
						take_end = out_free;
						pop      = out_free;
					end else begin
						take_mod = 1'b1;
						pop      = 1'b1;
					end
				end
			end
			S_MODS: begin
				ld_mod = out_free;
			end
			default: ;
		endcase
	end

	assign st_we = (take_mod || take_end) && head_cmd.mod_vld;
	assign ld    = take_text || take_end || ld_mod;

	always_comb begin
		rec_type  = REC_MOD;
		rec_kind  = walk_kind_q;
		rec_value = 32'(store_q[idx_q[IDX_W-1:0]]);
		rec_count = 4'h0;
		rec_last  = walk_last;
		priority if (take_text) begin
			rec_type  = REC_TEXT;
			rec_kind  = KIND_TEXT;
			rec_value = 32'(head_cmd.text_byte);
			rec_last  = 1'b0;
		end else if (take_end) begin
			rec_type  = REC_HEADER;
			rec_kind  = head_cmd.kind;
			rec_value = key_kind ? 32'(head_cmd.key) : 32'h0;
			rec_count = 4'(total_w);
			rec_last  = total_w == '0;
		end else begin
			rec_type = REC_MOD;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_q[cnt_q[IDX_W-1:0]] <= CODE_WIDTH'(head_cmd.mod_val);
		end
		if (ld) begin
			type_q  <= rec_type;
			kind_q  <= rec_kind;
			value_q <= rec_value;
			count_q <= rec_count;
			last_q  <= rec_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_HEAD;
			cnt_q       <= '0;
			total_q     <= '0;
			idx_q       <= '0;
			walk_kind_q <= KIND_NONE;
			text_done_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (ld) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (take_text && head_cmd.end_vld) begin
				text_done_q <= 1'b1;
			end
			if (take_mod) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (take_end) begin
				text_done_q <= 1'b0;
				cnt_q       <= '0;
				if (total_w != '0) begin
					state_q     <= S_MODS;
					total_q     <= total_w;
					idx_q       <= '0;
					walk_kind_q <= head_cmd.kind;
				end
			end
			if (ld_mod) begin
				idx_q <= idx_q + CNT_W'(1);
				if (walk_last) begin
					state_q <= S_HEAD;
				end
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'h0, count_q, value_q};
	assign m_tuser  = {kind_q, type_q};
	assign m_tlast  = last_q;

	a_walk_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MODS |-> idx_q < total_q)
		else $error("modifier walk index past total");

	a_walk_record: assert property (@(posedge clk) disable iff (!arst_n)
		ld_mod |=> out_vld_q && type_q == REC_MOD)
		else $error("modifier walk loaded a wrong record");

	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_MODS))
		else $error("modifier store count out of range");

endmodule

[rtl/key_event_text_parser.sv]
// Top level of the key/text event line parser: parser front, command queue, record back end.
// Path: a byte's command is written into a queue slot, and its record is then loaded into the output register.
// Throughput: one byte per cycle while the four-entry command queue has room.
// End of line: header then, for a key event, one record per stored modifier, one record per cycle
//   while m_tready is high, so a line ends in up to MAX_MODS+1 records at the back end.
// Reset: arst_n clears parser, queue and output control at once; the modifier store is not cleared.
module key_event_text_parser
	import ketp_pkg::*;
#(
	parameter int MAX_MODS   = MAX_MODS_DEF,  // modifier store depth, 1 to 15
	parameter int CODE_WIDTH = CODE_WIDTH_DEF // bits kept of a key or modifier code, 8 to 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input characters
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // in_last
	// output records
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] value, [35:32] modifier_count, [39:36] zero
	output logic [3:0]  m_tuser,   // [1:0] record_type, [3:2] event_kind
	output logic        m_tlast    // last_of_run
);

	logic accept;
	logic push, full, pop, head_vld;
	cmd_t push_cmd, head_cmd;

	// A byte is taken whenever the queue can hold whatever command it produces;
	// the front never waits on the back end otherwise.
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	// Front: run the per-character parse and emit at most one command per byte.
	ketp_front #(
		.MAX_MODS   (MAX_MODS),
		.CODE_WIDTH (CODE_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.push    (push),
		.cmd     (push_cmd)
	);

	// Queue: decouple the character stream from the end-of-line record burst.
	ketp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head_vld (head_vld),
		.head_cmd (head_cmd)
	);

	// Back: hold the modifier store, build text, header and modifier records,
	// and drive the output register, which advances on each transfer.
	ketp_back #(
		.MAX_MODS   (MAX_MODS),
		.CODE_WIDTH (CODE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_vld (head_vld),
		.head_cmd (head_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
